// ===== rtl/salm_pkg.sv =====
// Shared types, constants and state encoding for the sent action latency matcher.
package salm_pkg;

    localparam int QUEUE_DEPTH_DEF = 256;

    localparam logic [7:0]  CODE_FIRST    = 8'h10;
    localparam logic [7:0]  CODE_LAST     = 8'h14;
    localparam logic [15:0] MAX_LAG_RESET = 16'd2500;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_ACK    = 1'b1;

    typedef struct packed {
        logic        command;
        logic [7:0]  action_code;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic        lag_valid;
        logic [31:0] lag_ms;
        logic        matched;
        logic        dropped_oldest;
    } t_out_item;

    // One pending entry: code offset from CODE_FIRST and send time.
    typedef struct packed {
        logic [2:0]  code;
        logic [31:0] stamp;
    } t_entry;

    // Per-cycle command to every cell of the chain.
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctrl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REC,
        S_SCAN,
        S_POP,
        S_EMIT
    } t_state;

endpackage

// ===== rtl/salm_cell.sv =====
// One queue cell: holds an entry, loads the broadcast entry or its right neighbor.
module salm_cell #(
    parameter int               IDX_W    = 8,
    parameter logic [IDX_W-1:0] CELL_IDX = '0
) (
    input  logic                i_clk,
    input  salm_pkg::t_cell_ctrl i_ctrl,
    input  logic [IDX_W-1:0]    i_target,
    input  salm_pkg::t_entry    i_bcast,
    input  salm_pkg::t_entry    i_next,
    output salm_pkg::t_entry    o_entry
);
    import salm_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.load && (i_target == CELL_IDX)) begin
            n_entry = i_bcast;
        end else if (i_ctrl.shift) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== rtl/sent_action_latency_matcher_top.sv =====
// Top level of the sent action latency matcher: control sequencer and cell chain.
//
// Usage: input beats carry {command, action_code, now_ms}; each accepted beat
// yields exactly one output beat {lag_valid, lag_ms, matched, dropped_oldest}.
// Pending entries live in a chain of QUEUE_DEPTH cells, cell 0 being the
// oldest. A record beat loads the tail cell (or shifts the chain by one and
// loads the last cell when the queue is full, flagging the drop). An
// acknowledge beat scans from cell 0: on a mismatch the live region rotates
// by one, so after k steps the match sits in cell 0 and the k skipped entries
// sit at the back, where shrinking the count discards them. With no match the
// scan rotates the whole live region once and leaves it as it was. Matching
// leading entries are then shifted out, one per cycle.
// An ignored code goes straight to the emit state; a record beat passes
// the record state first; an acknowledge beat scans k entries (up to the
// live count), one a cycle, then pops p entries before the emit state.
// One beat is processed at a time; the input stalls while it is in flight.
// The result sits in an output register, so the next beat is taken while a
// finished result waits; a stalled output only holds back the following one.
// Reset (synchronous, active low) empties the queue and loads max_lag_ms
// with 2500; cells are not cleared. The config write channel is always ready;
// the user must write it only while the block is idle; it is not enforced.
module sent_action_latency_matcher_top #(
    parameter int QUEUE_DEPTH = salm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  salm_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output salm_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data
);
    import salm_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] TAIL_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    t_state             r_state, n_state;
    logic [2:0]         r_code;
    logic [31:0]        r_now;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_k, n_k;
    t_out_item          r_res, n_res;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out_data, n_out_data;
    logic [15:0]        r_max_lag;

    t_cell_ctrl         w_ctrl;
    logic [IDX_W-1:0]   w_target;
    t_entry             w_bcast;
    t_entry             w_entry [QUEUE_DEPTH];
    t_entry             w_head;
    logic               w_in_acc;
    logic               w_out_free;
    logic [2:0]         w_code_diff;
    logic               w_in_code_ok;
    logic [31:0]        w_lag;
    logic               w_head_hit;

    // ---------------- cell chain ----------------
    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        t_entry w_next;
        if (gi == QUEUE_DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_entry[gi+1];
        end
        salm_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (IDX_W'(gi))
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctrl   (w_ctrl),
            .i_target (w_target),
            .i_bcast  (w_bcast),
            .i_next   (w_next),
            .o_entry  (w_entry[gi])
        );
    end

    assign w_head = w_entry[0];

    // ---------------- input decode ----------------
    assign w_in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall   = (r_state != S_IDLE);
    assign w_code_diff  = i_in_data.action_code[2:0] - CODE_FIRST[2:0];
    assign w_in_code_ok = (i_in_data.action_code >= CODE_FIRST) &&
                          (i_in_data.action_code <= CODE_LAST);

    // Lag against the head entry; modulo 2^32 by plain wraparound.
    assign w_lag      = r_now - w_head.stamp;
    assign w_head_hit = (w_head.code == r_code);

    // Output register frees up when empty or being taken this cycle.
    assign w_out_free = !r_out_valid || !i_out_stall;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (!w_in_code_ok) begin
                        n_state = S_EMIT;
                    end else if (i_in_data.command == CMD_RECORD) begin
                        n_state = S_REC;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_REC: begin
                n_state = S_EMIT;
            end
            S_SCAN: begin
                if (r_k == r_count) begin
                    n_state = S_EMIT;
                end else if (w_head_hit) begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if ((r_count == '0) || !w_head_hit) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- datapath and cell control ----------------
    always_comb begin
        n_count     = r_count;
        n_k         = r_k;
        n_res       = r_res;
        w_ctrl      = '0;
        w_target    = TAIL_IDX;
        w_bcast     = w_head;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_res = '0;
                    n_k   = '0;
                end
            end
            S_REC: begin
                // Append; on a full queue drop the head and append at the end.
                w_bcast.code  = r_code;
                w_bcast.stamp = r_now;
                w_ctrl.load   = 1'b1;
                if (r_count == FULL_CNT) begin
                    w_ctrl.shift         = 1'b1;
                    w_target             = TAIL_IDX;
                    n_res.dropped_oldest = 1'b1;
                end else begin
                    w_target = r_count[IDX_W-1:0];
                    n_count  = r_count + CNT_ONE;
                end
            end
            S_SCAN: begin
                if (r_k != r_count) begin
                    if (w_head_hit) begin
                        // Discard the skipped entries now parked at the back.
                        n_count         = r_count - r_k;
                        n_res.matched   = 1'b1;
                        n_res.lag_ms    = w_lag;
                        n_res.lag_valid = (w_lag != 32'd0) &&
                                          (w_lag < {16'd0, r_max_lag});
                    end else begin
                        // Rotate the live region: head goes to the last live cell.
                        w_ctrl.shift = 1'b1;
                        w_ctrl.load  = 1'b1;
                        w_bcast      = w_head;
                        w_target     = IDX_W'(r_count - CNT_ONE);
                        n_k          = r_k + CNT_ONE;
                    end
                end
            end
            S_POP: begin
                if ((r_count != '0) && w_head_hit) begin
                    w_ctrl.shift = 1'b1;
                    n_count      = r_count - CNT_ONE;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                end
            end
            default: ;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            r_max_lag   <= MAX_LAG_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_lag <= i_cfg_data;
            end
        end
    end

    // Payload: hold the accepted beat and the result under construction.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_code <= w_code_diff;
            r_now  <= i_in_data.now_ms;
        end
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
